FILE: rtl/ihrc_pkg.sv
// shared types, constants and field widths for the ipv4 header receive check
package ihrc_pkg;

   localparam int HEADER_WORDS = 10;

   localparam int WORD_WIDTH  = 16;
   localparam int SUM_WIDTH   = 20;
   localparam int PROTO_WIDTH = 8;
   localparam int CLASS_WIDTH = 2;

   localparam int FLAGS_WORD_INDEX = 3;
   localparam int PROTO_WORD_INDEX = 4;

   localparam logic [WORD_WIDTH-1:0] MF_BIT      = 16'h2000;
   localparam logic [WORD_WIDTH-1:0] OFFSET_MASK = 16'h1FFF;
   localparam logic [WORD_WIDTH-1:0] FOLD_OK     = 16'hFFFF;

   localparam logic [PROTO_WIDTH-1:0] PROTO_ICMP = 8'd1;
   localparam logic [PROTO_WIDTH-1:0] PROTO_TCP  = 8'd6;
   localparam logic [PROTO_WIDTH-1:0] PROTO_UDP  = 8'd17;

   typedef enum logic [CLASS_WIDTH-1:0] {
      CLASS_ICMP  = 2'd0,
      CLASS_TCP   = 2'd1,
      CLASS_UDP   = 2'd2,
      CLASS_OTHER = 2'd3
   } protocol_class_type;

   typedef struct packed {
      logic                   checksum_ok;
      logic                   fragment;
      logic                   accept;
      protocol_class_type     protocol_class;
      logic [PROTO_WIDTH-1:0] protocol_number;
   } result_type;

endpackage

FILE: rtl/ihrc_if.sv
// valid/ready channel interfaces for header words and check results
interface ihrc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ihrc_pkg::WORD_WIDTH-1:0]  header_word;
   logic                             first_word;

   modport source (output valid, output header_word, output first_word, input ready);
   modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

interface ihrc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              checksum_ok;
   logic                              fragment;
   logic                              accept;
   logic [ihrc_pkg::CLASS_WIDTH-1:0]  protocol_class;
   logic [ihrc_pkg::PROTO_WIDTH-1:0]  protocol_number;

   modport source (output valid, output checksum_ok, output fragment, output accept,
                   output protocol_class, output protocol_number, input ready);
   modport sink   (input valid, input checksum_ok, input fragment, input accept,
                   input protocol_class, input protocol_number, output ready);
endinterface

FILE: rtl/ipv4_header_rx_check_top.sv
// top level of the ipv4 header receive check: word accumulator and result register
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+----------------------------------------------
//   req     | in  | valid / ready    | header_word[15:0], first_word
//   rsp     | out | valid / ready    | checksum_ok, fragment, accept,
//           |     |                  | protocol_class[1:0], protocol_number[7:0]
//
// one header word is taken per cycle unless stalled; a header of HEADER_WORDS words gives
// one result item in the cycle after its last word is taken (sum, fold, compare at take)
// reset (synchronous, active high) clears the word position, the sum, the stored
// flags word and protocol byte, and the result valid
// a stalled result holds back only the word at the last position; all other words
// keep flowing while the result register waits
module ipv4_header_rx_check_top #(
   parameter int HEADER_WORDS = ihrc_pkg::HEADER_WORDS
) (
   input  logic      clock,
   input  logic      reset,
   ihrc_req_if.sink  req,
   ihrc_rsp_if.source rsp
);

   localparam int POS_W = $clog2(HEADER_WORDS);
   localparam int WW    = ihrc_pkg::WORD_WIDTH;
   localparam int SW    = ihrc_pkg::SUM_WIDTH;
   localparam int PW    = ihrc_pkg::PROTO_WIDTH;
   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(HEADER_WORDS - 1);
   localparam logic [POS_W-1:0] FLAGS_POS = POS_W'(ihrc_pkg::FLAGS_WORD_INDEX);
   localparam logic [POS_W-1:0] PROTO_POS = POS_W'(ihrc_pkg::PROTO_WORD_INDEX);

   // header state
   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [SW-1:0]    sum_ff,   sum_in;
   logic [WW-1:0]    flags_ff, flags_in;
   logic [PW-1:0]    proto_ff, proto_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   ihrc_pkg::result_type rsp_data_ff,  rsp_data_in;

   logic                 req_take;
   logic                 rsp_take;
   logic [POS_W-1:0]     pos_eff;
   logic [SW-1:0]        sum_base;
   logic                 last_word;
   ihrc_pkg::result_type calc_result;

   // a marked word always restarts the header at word zero
   assign pos_eff   = req.first_word ? '0 : pos_ff;
   assign sum_base  = req.first_word ? '0 : sum_ff;
   assign last_word = (pos_eff == LAST_POS);

   // the result slot is needed only when a last word can land; the test uses the
   // stored position so ready does not depend on the payload
   assign req.ready = !((pos_ff == LAST_POS) && rsp_valid_ff && !rsp.ready);
   assign req_take  = req.valid && req.ready;
   assign rsp_take  = rsp_valid_ff && rsp.ready;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      flags_in = flags_ff;
      proto_in = proto_ff;
      if (req_take) begin
         sum_in = sum_base + {{(SW-WW){1'b0}}, req.header_word};
         if (pos_eff == FLAGS_POS) begin
            flags_in = req.header_word;
         end
         if (pos_eff == PROTO_POS) begin
            proto_in = req.header_word[PW-1:0];
         end
         if (last_word) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_eff + 1'b1;
         end
      end
   end

   // fold runs on the sum including the last word; flags and protocol are
   // already stored by then
   ihrc_result_calc u_calc (
      .sum        (sum_base + {{(SW-WW){1'b0}}, req.header_word}),
      .flags_word (flags_ff),
      .proto_byte (proto_ff),
      .result     (calc_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;
      if (req_take && last_word) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = calc_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         flags_ff     <= '0;
         proto_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         flags_ff     <= flags_in;
         proto_ff     <= proto_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.checksum_ok     = rsp_data_ff.checksum_ok;
   assign rsp.fragment        = rsp_data_ff.fragment;
   assign rsp.accept          = rsp_data_ff.accept;
   assign rsp.protocol_class  = rsp_data_ff.protocol_class;
   assign rsp.protocol_number = rsp_data_ff.protocol_number;

`ifndef SYNTHESIS
   // a taken last word always shows up as a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take && last_word |=> rsp_valid_ff)
      else $error("last header word did not load a result");

   // a waiting result is never overwritten by a last word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready && pos_ff == LAST_POS |-> !req.ready)
      else $error("last word taken while result stalled");

   // the word position stays inside the header
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("word position out of range");

   // sum is cleared after every finished header
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      req_take && last_word |=> sum_ff == '0 && pos_ff == '0)
      else $error("sum or position not cleared after header");
`endif

endmodule

FILE: rtl/ihrc_result_calc.sv
// end-around carry fold of the header sum, fragment test and protocol class
module ihrc_result_calc (
   input  logic [ihrc_pkg::SUM_WIDTH-1:0]   sum,
   input  logic [ihrc_pkg::WORD_WIDTH-1:0]  flags_word,
   input  logic [ihrc_pkg::PROTO_WIDTH-1:0] proto_byte,
   output ihrc_pkg::result_type             result
);

   localparam int WW = ihrc_pkg::WORD_WIDTH;
   localparam int CW = ihrc_pkg::SUM_WIDTH - ihrc_pkg::WORD_WIDTH;

   logic [WW:0]   fold1;
   logic [WW-1:0] fold2;
   logic          frag;
   ihrc_pkg::protocol_class_type cls;

   // two folds are enough: the first leaves at most one carry bit
   assign fold1 = {1'b0, sum[WW-1:0]} + {{(WW+1-CW){1'b0}}, sum[ihrc_pkg::SUM_WIDTH-1:WW]};
   assign fold2 = fold1[WW-1:0] + {{(WW-1){1'b0}}, fold1[WW]};

   assign frag = ((flags_word & ihrc_pkg::MF_BIT) != '0) ||
                 ((flags_word & ihrc_pkg::OFFSET_MASK) != '0);

   always_comb begin
      case (proto_byte)
         ihrc_pkg::PROTO_ICMP: cls = ihrc_pkg::CLASS_ICMP;
         ihrc_pkg::PROTO_TCP:  cls = ihrc_pkg::CLASS_TCP;
         ihrc_pkg::PROTO_UDP:  cls = ihrc_pkg::CLASS_UDP;
         default:              cls = ihrc_pkg::CLASS_OTHER;
      endcase
   end

   always_comb begin
      result.checksum_ok     = (fold2 == ihrc_pkg::FOLD_OK);
      result.fragment        = frag;
      result.accept          = (fold2 == ihrc_pkg::FOLD_OK) && !frag;
      result.protocol_class  = cls;
      result.protocol_number = proto_byte;
   end

endmodule
